// ----- rtl/ledfx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED effect package
// Shared constants and types for the LED effect engine and its HSV colour unit.
// ----------------------------------------------------------------------------
package ledfx_pkg;

    // Width of the effect tick counter.
    localparam int TIMER_BITS = 16;
    // Counter compare width: wide enough for the counter, the period and a carry.
    localparam int CMP_W = ((TIMER_BITS > 16) ? TIMER_BITS : 16) + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_STATE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_MS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATHE_MS = 3'd6;

    // Effect modes.
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_SOLID   = 2'd1;
    localparam logic [1:0] MODE_BLINK   = 2'd2;
    localparam logic [1:0] MODE_BREATHE = 2'd3;

    // Breathe triangle limits.
    localparam logic [7:0] BREATHE_MIN = 8'd5;
    localparam logic [7:0] BREATHE_MAX = 8'd255;

    // Reciprocal constants for the constant divisions in the colour unit.
    localparam logic [15:0] RECIP60         = 16'd17477;
    localparam int          RECIP60_SHIFT   = 20;
    localparam logic [15:0] RECIP100        = 16'd41944;
    localparam int          RECIP100_SHIFT  = 22;
    localparam logic [6:0]  SAT_FULL        = 7'd100;
    localparam logic [8:0]  DEG_PER_SECTOR  = 9'd60;

    // Request from the effect sequencer to the colour unit.
    typedef struct packed {
        logic       start;
        logic [7:0] value;
    } frame_req_t;

    // Colour settings seen by the colour unit.
    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] saturation;
    } color_cfg_t;

endpackage
`default_nettype wire

// ----- rtl/ledfx_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED effect sequencer
// Holds the configuration registers and the effect state, advances the tick
// counter on each accepted word and requests a colour frame when one is due.
// ----------------------------------------------------------------------------
module ledfx_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [ledfx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ledfx_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                              in_valid,
    input  wire logic                              restart,
    input  wire logic                              busy,
    output ledfx_pkg::frame_req_t                  req,
    output ledfx_pkg::color_cfg_t                  color_cfg
);

    // Configuration registers.
    logic [1:0]  mode_reg;
    logic        on_state_reg;
    logic [8:0]  hue_reg;
    logic [6:0]  saturation_reg;
    logic [7:0]  brightness_reg;
    logic [15:0] blink_period_reg;
    logic [7:0]  breathe_step_reg;

    // Effect state.
    logic [ledfx_pkg::TIMER_BITS-1:0] phase_reg, phase_next;
    logic       lit_reg, lit_next;
    logic [7:0] level_reg, level_next;
    logic       falling_reg, falling_next;
    logic       solid_sent_reg, solid_sent_next;

    // Values after an optional restart.
    logic [ledfx_pkg::TIMER_BITS-1:0] phase_eff;
    logic       lit_eff;
    logic [7:0] level_eff;
    logic       falling_eff;
    logic       solid_eff;
    logic       accept;
    logic       frame;
    logic [7:0] frame_value;
    logic [7:0] level_step;

    // Counter advance: wraps at period - 1, at all ones, and treats 0 as 1.
    function automatic logic [ledfx_pkg::TIMER_BITS-1:0] advance(
        input logic [ledfx_pkg::TIMER_BITS-1:0] ph,
        input logic [15:0]                      per
    );
        logic [ledfx_pkg::CMP_W-1:0] p;
        logic [ledfx_pkg::CMP_W-1:0] nx;
        p  = (per == 16'd0) ? ledfx_pkg::CMP_W'(1) : ledfx_pkg::CMP_W'(per);
        nx = ledfx_pkg::CMP_W'(ph) + ledfx_pkg::CMP_W'(1);
        if ((nx >= p) || (ph == '1))
        begin
            return '0;
        end
        return ph + ledfx_pkg::TIMER_BITS'(1);
    endfunction

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= ledfx_pkg::MODE_IDLE;
            on_state_reg     <= 1'b0;
            hue_reg          <= 9'd0;
            saturation_reg   <= 7'd0;
            brightness_reg   <= 8'd255;
            blink_period_reg <= 16'd500;
            breathe_step_reg <= 8'd10;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ledfx_pkg::CFG_MODE:       mode_reg         <= cfg_data[1:0];
                ledfx_pkg::CFG_ON_STATE:   on_state_reg     <= cfg_data[0];
                ledfx_pkg::CFG_HUE:        hue_reg          <= cfg_data[8:0];
                ledfx_pkg::CFG_SATURATION: saturation_reg   <= cfg_data[6:0];
                ledfx_pkg::CFG_BRIGHTNESS: brightness_reg   <= cfg_data[7:0];
                ledfx_pkg::CFG_BLINK_MS:   blink_period_reg <= cfg_data[15:0];
                ledfx_pkg::CFG_BREATHE_MS: breathe_step_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign accept = in_valid && !busy;

    // Restart overrides the stored state for this tick.
    assign phase_eff   = restart ? '0 : phase_reg;
    assign lit_eff     = restart ? on_state_reg : lit_reg;
    assign level_eff   = restart ? ledfx_pkg::BREATHE_MIN : level_reg;
    assign falling_eff = restart ? 1'b0 : falling_reg;
    assign solid_eff   = restart ? 1'b0 : solid_sent_reg;

    // Breathe level after one step in the current direction.
    always_comb
    begin
        level_step = level_eff;
        if (!falling_eff)
        begin
            if (level_eff < ledfx_pkg::BREATHE_MAX)
            begin
                level_step = level_eff + 8'd1;
            end
        end
        else if (level_eff > ledfx_pkg::BREATHE_MIN)
        begin
            level_step = level_eff - 8'd1;
        end
    end

    // Effect step for one tick.
    always_comb
    begin
        phase_next      = phase_eff;
        lit_next        = lit_eff;
        level_next      = level_eff;
        falling_next    = falling_eff;
        solid_sent_next = solid_eff;
        frame           = 1'b0;
        frame_value     = 8'd0;
        unique case (mode_reg)
            ledfx_pkg::MODE_SOLID:
            begin
                if (!solid_eff)
                begin
                    frame           = 1'b1;
                    frame_value     = on_state_reg ? brightness_reg : 8'd0;
                    solid_sent_next = 1'b1;
                end
            end
            ledfx_pkg::MODE_BLINK:
            begin
                if (phase_eff == '0)
                begin
                    frame       = 1'b1;
                    lit_next    = !lit_eff;
                    frame_value = !lit_eff ? brightness_reg : 8'd0;
                end
                phase_next = advance(phase_eff, blink_period_reg);
            end
            ledfx_pkg::MODE_BREATHE:
            begin
                if (phase_eff == '0)
                begin
                    frame       = 1'b1;
                    frame_value = level_eff;
                    level_next  = level_step;
                    if (!falling_eff)
                    begin
                        falling_next = (level_step >= ledfx_pkg::BREATHE_MAX);
                    end
                    else
                    begin
                        falling_next = !(level_step <= ledfx_pkg::BREATHE_MIN);
                    end
                end
                phase_next = advance(phase_eff, 16'(breathe_step_reg));
            end
            default: ;
        endcase
    end

    // State update on each accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= '0;
            lit_reg        <= 1'b0;
            level_reg      <= ledfx_pkg::BREATHE_MIN;
            falling_reg    <= 1'b0;
            solid_sent_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            lit_reg        <= lit_next;
            level_reg      <= level_next;
            falling_reg    <= falling_next;
            solid_sent_reg <= solid_sent_next;
        end
    end

    assign req.start            = accept && frame;
    assign req.value            = frame_value;
    assign color_cfg.hue        = hue_reg;
    assign color_cfg.saturation = saturation_reg;

endmodule
`default_nettype wire

// ----- rtl/ledfx_color.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB colour unit
// Six-sector integer conversion run through one shared 16x16 multiplier under
// a small sequencer; constant divisions use reciprocal multiplies.
// ----------------------------------------------------------------------------
module ledfx_color (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ledfx_pkg::frame_req_t req,
    input  wire ledfx_pkg::color_cfg_t color_cfg,
    output logic                       busy,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 red,
    output logic [7:0]                 green,
    output logic [7:0]                 blue
);

    // Sequencer steps.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SEC  = 3'd1;
    localparam logic [2:0] ST_LOP  = 3'd2;
    localparam logic [2:0] ST_LO   = 3'd3;
    localparam logic [2:0] ST_ADJP = 3'd4;
    localparam logic [2:0] ST_ADJ  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    // Hue sectors; every sector from five upward uses the last formula.
    localparam logic [3:0] SEC_RISE_G = 4'd0;
    localparam logic [3:0] SEC_FALL_R = 4'd1;
    localparam logic [3:0] SEC_RISE_B = 4'd2;
    localparam logic [3:0] SEC_FALL_G = 4'd3;
    localparam logic [3:0] SEC_RISE_R = 4'd4;

    logic [2:0]  state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  v_reg;
    logic [29:0] prod_reg;
    logic [3:0]  sector_reg;
    logic [5:0]  rem_reg;
    logic [7:0]  lo_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;

    logic [15:0] mul_a, mul_b;
    logic [31:0] prod;
    logic [6:0]  sat_c;
    logic [3:0]  sector_calc;
    logic [5:0]  rem_calc;
    logic [7:0]  lo_calc;
    logic [7:0]  adj_calc;
    logic [7:0]  r_calc, g_calc, b_calc;
    logic        load_out;

    assign sat_c = (color_cfg.saturation > ledfx_pkg::SAT_FULL) ?
                   ledfx_pkg::SAT_FULL : color_cfg.saturation;

    // Quotients read from the product register.
    assign sector_calc = 4'(prod_reg >> ledfx_pkg::RECIP60_SHIFT);
    assign rem_calc    = 6'(color_cfg.hue - 9'(sector_calc * ledfx_pkg::DEG_PER_SECTOR));
    assign lo_calc     = 8'(prod_reg >> ledfx_pkg::RECIP100_SHIFT);
    assign adj_calc    = 8'(prod_reg >> ledfx_pkg::RECIP60_SHIFT);

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = 16'd0;
        mul_b = 16'd0;
        unique case (state_reg)
            ST_SEC:
            begin
                mul_a = 16'(color_cfg.hue);
                mul_b = ledfx_pkg::RECIP60;
            end
            ST_LOP:
            begin
                mul_a = 16'(v_reg);
                mul_b = 16'(ledfx_pkg::SAT_FULL - sat_c);
            end
            ST_LO:
            begin
                mul_a = 16'(prod_reg[14:0]);
                mul_b = ledfx_pkg::RECIP100;
            end
            ST_ADJP:
            begin
                mul_a = 16'(v_reg - lo_calc);
                mul_b = 16'(rem_reg);
            end
            ST_ADJ:
            begin
                mul_a = 16'(prod_reg[13:0]);
                mul_b = ledfx_pkg::RECIP60;
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // Channel assembly from the sector.
    always_comb
    begin
        unique case (sector_reg)
            SEC_RISE_G:
            begin
                r_calc = v_reg;
                g_calc = lo_reg + adj_calc;
                b_calc = lo_reg;
            end
            SEC_FALL_R:
            begin
                r_calc = v_reg - adj_calc;
                g_calc = v_reg;
                b_calc = lo_reg;
            end
            SEC_RISE_B:
            begin
                r_calc = lo_reg;
                g_calc = v_reg;
                b_calc = lo_reg + adj_calc;
            end
            SEC_FALL_G:
            begin
                r_calc = lo_reg;
                g_calc = v_reg - adj_calc;
                b_calc = v_reg;
            end
            SEC_RISE_R:
            begin
                r_calc = lo_reg + adj_calc;
                g_calc = lo_reg;
                b_calc = v_reg;
            end
            default:
            begin
                r_calc = v_reg;
                g_calc = lo_reg;
                b_calc = v_reg - adj_calc;
            end
        endcase
    end

    // The result loads once the output register is free or being emptied.
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: state_next = req.start ? ST_SEC : ST_IDLE;
            ST_SEC:  state_next = ST_LOP;
            ST_LOP:  state_next = ST_LO;
            ST_LO:   state_next = ST_ADJP;
            ST_ADJP: state_next = ST_ADJ;
            ST_ADJ:  state_next = ST_DONE;
            ST_DONE: state_next = load_out ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Output word valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (req.start && (state_reg == ST_IDLE))
        begin
            v_reg <= req.value;
        end
        if ((state_reg == ST_SEC) || (state_reg == ST_LOP) || (state_reg == ST_LO) ||
            (state_reg == ST_ADJP) || (state_reg == ST_ADJ))
        begin
            prod_reg <= prod[29:0];
        end
        if (state_reg == ST_LOP)
        begin
            sector_reg <= sector_calc;
            rem_reg    <= rem_calc;
        end
        if (state_reg == ST_ADJP)
        begin
            lo_reg <= lo_calc;
        end
        if (load_out)
        begin
            red_reg   <= r_calc;
            green_reg <= g_calc;
            blue_reg  <= b_calc;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule
`default_nettype wire

// ----- rtl/led_effect_hsv_to_rgb.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A tick that causes a frame passes through the colour unit steps SEC, LOP, LO, ADJP, ADJ
// and DONE before its word is registered onto out_valid. A tick with no frame does not
// stall; one with a frame holds in_stall over five multiplier passes and an assembly step.
// A finished frame waits in the output register while the next tick is accepted; a new
// frame that finds that register still stalled keeps in_stall high until it is taken.
// Reset (rst_n low, asynchronous) restores the register defaults and the effect state.
// ----------------------------------------------------------------------------
// LED effect engine top level
// Millisecond-tick effect sequencer (solid, blink, breathe) feeding an
// iterative HSV-to-RGB colour unit.
// ----------------------------------------------------------------------------
module led_effect_hsv_to_rgb (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [ledfx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ledfx_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              restart,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [7:0]                             red,
    output logic [7:0]                             green,
    output logic [7:0]                             blue
);

    ledfx_pkg::frame_req_t req;
    ledfx_pkg::color_cfg_t color_cfg;
    logic                  busy;

    // Effect sequencer and configuration registers.
    ledfx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .restart   (restart),
        .busy      (busy),
        .req       (req),
        .color_cfg (color_cfg)
    );

    // Colour conversion and output register.
    ledfx_color u_color (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .color_cfg (color_cfg),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    // A tick waits while a frame is being converted.
    assign in_stall = busy;

endmodule
`default_nettype wire

// ----- rtl/ledfx_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED effect port checker
// Port-level properties of the effect engine, bound to the top level.
// ----------------------------------------------------------------------------
module ledfx_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] red,
    input wire logic [7:0] green,
    input wire logic [7:0] blue
);

    // A stalled output word holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red) && $stable(green) &&
        $stable(blue))
        else $error("output word changed while stalled");

    // The engine only becomes busy because a tick was taken.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("input stall rose without an accepted tick");

    // A conversion ends by placing its word in the output register.
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("conversion ended without an output word");

    // A new output word only appears after a conversion.
    a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output word appeared without a conversion");

endmodule

bind led_effect_hsv_to_rgb ledfx_checker u_ledfx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red       (red),
    .green     (green),
    .blue      (blue)
);
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED effect engine testbench
// Drives millisecond ticks into the effect engine under random settings of
// every register, predicts each RGB word from its own copy of the effect
// state and colour math, and compares the words that come out in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ITEM_TARGET   = 1100;
    localparam int QUIET_AFTER   = 950;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int TIMEOUT_NS    = 5_000_000;

    // One RGB word as the block presents it.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_word_t;

    // Mirror of the effect engine: register copy, effect state and the queue
    // of RGB words still owed by the block.
    class effect_frames;
        logic [1:0]                       mode;
        bit                               on_state;
        logic [8:0]                       hue;
        logic [6:0]                       saturation;
        logic [7:0]                       brightness;
        logic [15:0]                      blink_ms;
        logic [7:0]                       breathe_ms;
        logic [ledfx_pkg::TIMER_BITS-1:0] phase_count;
        bit                               blink_lit;
        logic [7:0]                       level;
        bit                               falling;
        bit                               solid_sent;
        rgb_word_t                        owed_words[$];
        int                               fail_count;

        function new();
            mode        = ledfx_pkg::MODE_IDLE;
            on_state    = 1'b0;
            hue         = '0;
            saturation  = '0;
            brightness  = 8'd255;
            blink_ms    = 16'd500;
            breathe_ms  = 8'd10;
            phase_count = '0;
            blink_lit   = 1'b0;
            level       = ledfx_pkg::BREATHE_MIN;
            falling     = 1'b0;
            solid_sent  = 1'b0;
            fail_count  = 0;
        endfunction

        function void set_register(logic [ledfx_pkg::CFG_IDX_W-1:0] idx,
                                   logic [ledfx_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                ledfx_pkg::CFG_MODE:       mode       = data[1:0];
                ledfx_pkg::CFG_ON_STATE:   on_state   = data[0];
                ledfx_pkg::CFG_HUE:        hue        = data[8:0];
                ledfx_pkg::CFG_SATURATION: saturation = data[6:0];
                ledfx_pkg::CFG_BRIGHTNESS: brightness = data[7:0];
                ledfx_pkg::CFG_BLINK_MS:   blink_ms   = data[15:0];
                ledfx_pkg::CFG_BREATHE_MS: breathe_ms = data[7:0];
                default: ;
            endcase
        endfunction

        // Six-sector integer HSV to RGB; hue sectors past the last one fold
        // into the magenta sector.
        function rgb_word_t shade(int unsigned v);
            int unsigned h;
            int unsigned s;
            int unsigned lo;
            int unsigned adj;
            rgb_word_t   w;
            h   = 32'(hue);
            s   = (saturation > ledfx_pkg::SAT_FULL) ? 32'(ledfx_pkg::SAT_FULL) :
                  32'(saturation);
            lo  = (v * (100 - s)) / 100;
            adj = ((v - lo) * (h % ledfx_pkg::DEG_PER_SECTOR)) / ledfx_pkg::DEG_PER_SECTOR;
            case (h / ledfx_pkg::DEG_PER_SECTOR)
                0:       w = '{8'(v), 8'(lo + adj), 8'(lo)};
                1:       w = '{8'(v - adj), 8'(v), 8'(lo)};
                2:       w = '{8'(lo), 8'(v), 8'(lo + adj)};
                3:       w = '{8'(lo), 8'(v - adj), 8'(v)};
                4:       w = '{8'(lo + adj), 8'(lo), 8'(v)};
                default: w = '{8'(v), 8'(lo), 8'(v - adj)};
            endcase
            return w;
        endfunction

        // Tick counter wraps at period-1, or at all ones, whichever is first.
        function void step_counter(int unsigned period);
            longint unsigned span;
            longint unsigned pc;
            longint unsigned top;
            span = (period == 0) ? 1 : period;
            pc   = 64'(phase_count);
            top  = (64'd1 << ledfx_pkg::TIMER_BITS) - 1;
            if (pc + 1 >= span || pc >= top)
                phase_count = '0;
            else
                phase_count = phase_count + 1'b1;
        endfunction

        // Advance the effect by one accepted tick and queue any RGB word.
        function void note_tick(bit restart_now);
            if (restart_now) begin
                phase_count = '0;
                blink_lit   = on_state;
                level       = ledfx_pkg::BREATHE_MIN;
                falling     = 1'b0;
                solid_sent  = 1'b0;
            end
            case (mode)
                ledfx_pkg::MODE_SOLID: begin
                    if (!solid_sent) begin
                        owed_words.push_back(shade(on_state ? 32'(brightness) : 0));
                        solid_sent = 1'b1;
                    end
                end
                ledfx_pkg::MODE_BLINK: begin
                    if (phase_count == 0) begin
                        blink_lit = !blink_lit;
                        owed_words.push_back(shade(blink_lit ? 32'(brightness) : 0));
                    end
                    step_counter(32'(blink_ms));
                end
                ledfx_pkg::MODE_BREATHE: begin
                    if (phase_count == 0) begin
                        owed_words.push_back(shade(32'(level)));
                        if (!falling) begin
                            if (level < ledfx_pkg::BREATHE_MAX) level = level + 1'b1;
                            if (level >= ledfx_pkg::BREATHE_MAX) falling = 1'b1;
                        end else begin
                            if (level > ledfx_pkg::BREATHE_MIN) level = level - 1'b1;
                            if (level <= ledfx_pkg::BREATHE_MIN) falling = 1'b0;
                        end
                    end
                    step_counter(32'(breathe_ms));
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                fail_count++;
            end
        endfunction

        // Compare an accepted word with the oldest one owed.
        function void check_frame(rgb_word_t got);
            rgb_word_t want;
            if (owed_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual r=%0d g=%0d b=%0d",
                         $time, got.red, got.green, got.blue);
                fail_count++;
                return;
            end
            want = owed_words.pop_front();
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_write;
    logic [ledfx_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ledfx_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                             in_valid;
    logic                             in_stall;
    logic                             restart;
    logic                             out_valid;
    logic                             out_stall;
    logic [7:0]                       red;
    logic [7:0]                       green;
    logic [7:0]                       blue;

    effect_frames frames = new();
    int           items_sent = 0;
    bit           quiet = 1'b0;
    bit           hold_request = 1'b0;

    led_effect_hsv_to_rgb DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check every word accepted by the receiver.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            frames.check_frame({red, green, blue});
    end

    // Receiver: random stall bursts, one long hold on request, none at the end.
    initial
    begin : receiver_stall
        int n;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end else if (quiet || $urandom_range(0, 3) == 0) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
                for (int i = 0; i < n && !hold_request; i++) @(posedge clk);
            end else begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
                n = $urandom_range(0, 20);
                for (int i = 0; i < n && !hold_request; i++) @(posedge clk);
            end
        end
    end

    // Offer one tick and wait for the block to take it.
    task automatic send_tick(bit restart_now);
        in_valid <= 1'b1;
        restart  <= restart_now;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        frames.note_tick(restart_now);
        items_sent++;
        quiet = (items_sent >= QUIET_AFTER);
    endtask

    // Send a tick, then maybe leave a gap before the next one.
    task automatic tick(bit restart_now);
        send_tick(restart_now);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every owed word has come out.
    task automatic settle();
        in_valid <= 1'b0;
        while (frames.owed_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [ledfx_pkg::CFG_IDX_W-1:0] idx,
                                  logic [ledfx_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        frames.set_register(idx, data);
    endtask

    // Write all registers once the block has gone quiet.
    task automatic apply_settings(logic [1:0] m, bit on, int h, int sat, int bri,
                                  int blink, int breathe);
        settle();
        write_register(ledfx_pkg::CFG_MODE, ledfx_pkg::CFG_DATA_W'(m));
        write_register(ledfx_pkg::CFG_ON_STATE, ledfx_pkg::CFG_DATA_W'(on));
        write_register(ledfx_pkg::CFG_HUE, ledfx_pkg::CFG_DATA_W'(h));
        write_register(ledfx_pkg::CFG_SATURATION, ledfx_pkg::CFG_DATA_W'(sat));
        write_register(ledfx_pkg::CFG_BRIGHTNESS, ledfx_pkg::CFG_DATA_W'(bri));
        write_register(ledfx_pkg::CFG_BLINK_MS, ledfx_pkg::CFG_DATA_W'(blink));
        write_register(ledfx_pkg::CFG_BREATHE_MS, ledfx_pkg::CFG_DATA_W'(breathe));
        cfg_write <= 1'b0;
    endtask

    function automatic int pick_hue();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
    endfunction

    function automatic int pick_saturation();
        return ($urandom_range(0, 5) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
    endfunction

    function automatic int pick_brightness();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 255 : 0;
        return $urandom_range(0, 255);
    endfunction

    // Random register set, weighted toward blink and breathe with short periods.
    task automatic random_settings();
        int          pick;
        logic [1:0]  m;
        int          blink;
        int          breathe;
        pick = $urandom_range(0, 9);
        if (pick == 0)     m = ledfx_pkg::MODE_IDLE;
        else if (pick < 3) m = ledfx_pkg::MODE_SOLID;
        else if (pick < 7) m = ledfx_pkg::MODE_BLINK;
        else               m = ledfx_pkg::MODE_BREATHE;
        pick = $urandom_range(0, 39);
        if (pick == 0)      blink = 16'hFFFF;
        else if (pick < 3)  blink = $urandom_range(0, 65535);
        else if (pick < 7)  blink = $urandom_range(9, 700);
        else                blink = $urandom_range(0, 8);
        breathe = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 255) : $urandom_range(0, 4);
        apply_settings(m, 1'($urandom_range(0, 1)), pick_hue(), pick_saturation(),
                       pick_brightness(), blink, breathe);
    endtask

    // A run of ticks; the first one usually restarts the effect.
    task automatic run_ticks(int count, bit first_restart);
        tick(first_restart);
        for (int i = 1; i < count; i++)
            tick($urandom_range(0, 19) == 0);
    endtask

    initial
    begin : stimulus
        int phase;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        restart   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings are idle: neither tick may produce a word.
        tick(1'b0);
        tick(1'b1);
        // Solid lit at full saturation, then solid dark at clamped saturation.
        apply_settings(ledfx_pkg::MODE_SOLID, 1'b1, 0, 100, 255, 500, 10);
        tick(1'b1);
        tick(1'b0);
        tick(1'b0);
        apply_settings(ledfx_pkg::MODE_SOLID, 1'b0, 359, 127, 255, 500, 10);
        tick(1'b1);
        tick(1'b0);
        // Blink with a zero period toggles on every tick.
        apply_settings(ledfx_pkg::MODE_BLINK, 1'b0, 60, 50, 200, 0, 10);
        tick(1'b1);
        repeat (3) tick(1'b0);
        // Longest blink period, hue past the last sector, dark brightness.
        apply_settings(ledfx_pkg::MODE_BLINK, 1'b1, 511, 101, 0, 16'hFFFF, 10);
        tick(1'b1);
        tick(1'b0);
        tick(1'b0);
        // Breathe at step one, then zero step carried on without a restart.
        apply_settings(ledfx_pkg::MODE_BREATHE, 1'b0, 120, 0, 255, 2, 1);
        tick(1'b1);
        repeat (4) tick(1'b0);
        apply_settings(ledfx_pkg::MODE_BREATHE, 1'b1, 240, 100, 255, 2, 0);
        repeat (3) tick(1'b0);
        apply_settings(ledfx_pkg::MODE_SOLID, 1'b1, 419, 75, 128, 2, 255);
        tick(1'b1);
        tick(1'b0);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase == 2) begin
                // Hold the receiver while a word per tick keeps coming.
                apply_settings(ledfx_pkg::MODE_BLINK, 1'($urandom_range(0, 1)), pick_hue(),
                               pick_saturation(), pick_brightness(), 1, 10);
                hold_request = 1'b1;
                send_tick(1'b1);
                repeat (39) send_tick(1'b0);
            end else if (phase == 4) begin
                // A full breathe triangle up to the top and back down.
                apply_settings(ledfx_pkg::MODE_BREATHE, 1'($urandom_range(0, 1)), pick_hue(),
                               pick_saturation(), pick_brightness(), 500,
                               $urandom_range(0, 1));
                tick(1'b1);
                repeat (529) tick(1'b0);
            end else begin
                random_settings();
                run_ticks($urandom_range(20, 80), $urandom_range(0, 3) != 0);
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (frames.owed_words.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (frames.fail_count == 0 && frames.owed_words.size() == 0)
            $display("** led_effect_hsv_to_rgb: PASSED **");
        else
            $display("** led_effect_hsv_to_rgb: FAILED **");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d words still owed", $time, frames.owed_words.size());
        $display("** led_effect_hsv_to_rgb: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ledfx_pkg.sv
rtl/ledfx_ctrl.sv
rtl/ledfx_color.sv
rtl/led_effect_hsv_to_rgb.sv
rtl/ledfx_checker.sv
bench/testbench.sv
